### src/rpn_pkg.sv
package rpn_pkg;

  localparam int WORD_W          = 32;
  localparam int STACK_DEPTH_DEF = 32;

  // token kinds on the input word
  localparam logic [2:0] KIND_DIGIT = 3'd0;
  localparam logic [2:0] KIND_ADD   = 3'd1;
  localparam logic [2:0] KIND_SUB   = 3'd2;
  localparam logic [2:0] KIND_MUL   = 3'd3;
  localparam logic [2:0] KIND_DIV   = 3'd4;
  localparam logic [2:0] KIND_BAD   = 3'd5;
  localparam logic [2:0] KIND_END   = 3'd6;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MALFORMED = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_LEFTOVER  = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;
  localparam logic [2:0] ST_FIRST     = 3'd6;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [3:0] digit_value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [2:0]               status;
  } out_t;

  // command classes handed from front to back
  typedef enum logic [2:0] {
    CL_PUSH,
    CL_ADD,
    CL_SUB,
    CL_MUL,
    CL_DIV,
    CL_ERR,
    CL_END
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic [2:0] err;
  } cmd_t;

endpackage

### src/rpn_ram.sv
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/rpn_div.sv
module rpn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpn_pkg::WORD_W-1:0] dividend,
  input  logic [rpn_pkg::WORD_W-1:0] divisor,
  output logic                      done,
  output logic [rpn_pkg::WORD_W-1:0] quotient
);
  import rpn_pkg::*;

  localparam int CW = $clog2(WORD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [WORD_W-1:0] den_r, den_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   trial;

  // restoring division on magnitudes, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, quo_r[WORD_W-1]};
    trial    = shifted - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      neg_nxt  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      quo_nxt  = dividend[WORD_W-1] ? -dividend : dividend;
      den_nxt  = divisor[WORD_W-1] ? -divisor : divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!trial[WORD_W]) begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

### src/rpn_front.sv
module rpn_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpn_pkg::in_t  in_data,
  output logic          cmd_valid,
  output rpn_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import rpn_pkg::*;

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);

  cmd_t             q_r [QD];
  logic [QAW-1:0]   wr_r, wr_nxt;
  logic [QAW-1:0]   rd_r, rd_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             first_r, first_nxt;
  logic             push;
  cmd_t             cls_word;

  assign in_ready  = cnt_r != (QAW+1)'(QD);
  assign cmd_valid = cnt_r != '0;
  assign cmd       = q_r[rd_r];
  assign push      = in_valid && in_ready;

  // token classification
  always_comb begin
    cls_word.cls   = CL_ERR;
    cls_word.digit = in_data.digit_value;
    cls_word.err   = ST_MALFORMED;
    case (in_data.token_kind)
      KIND_DIGIT: begin
        if (in_data.digit_value <= DIGIT_MAX) begin
          cls_word.cls = CL_PUSH;
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
        if (first_r) begin
          cls_word.err = ST_FIRST;
        end else if (in_data.token_kind == KIND_ADD) begin
          cls_word.cls = CL_ADD;
        end else if (in_data.token_kind == KIND_SUB) begin
          cls_word.cls = CL_SUB;
        end else if (in_data.token_kind == KIND_MUL) begin
          cls_word.cls = CL_MUL;
        end else begin
          cls_word.cls = CL_DIV;
        end
      end
      KIND_END: begin
        cls_word.cls = CL_END;
      end
      default: begin
        cls_word.cls = CL_ERR;
      end
    endcase
  end

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    if (push) begin
      wr_nxt    = wr_r + QAW'(1);
      first_nxt = in_data.token_kind == KIND_END;
    end
    if (cmd_pop) begin
      rd_nxt = rd_r + QAW'(1);
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      cnt_r   <= '0;
      first_r <= 1'b1;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
    end
    if (push) begin
      q_r[wr_r] <= cls_word;
    end
  end

endmodule

### src/rpn_back.sv
module rpn_back #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  rpn_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output rpn_pkg::out_t out_data
);
  import rpn_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_OPRD = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [WORD_W-1:0] tos_r, tos_nxt;
  cls_t              op_r, op_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic [DW-1:0]     depth_m1;
  logic [DW-1:0]     depth_m2;
  logic              ram_we;
  logic              ram_re;
  logic [WORD_W-1:0] lhs;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;
  logic              out_free;

  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);
  assign out_free = !out_valid_r || out_ready;

  // top of stack lives in tos_r, the entries below it in the ram
  rpn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_rpn_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_m1[AW-1:0]),
    .wdata (tos_r),
    .re    (ram_re),
    .raddr (depth_m2[AW-1:0]),
    .rdata (lhs)
  );

  rpn_div u_rpn_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lhs),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd.cls == CL_END) begin
          if (out_free) begin
            cmd_pop       = 1'b1;
            out_valid_nxt = 1'b1;
            out_data_nxt.value  = '0;
            out_data_nxt.status = err_r;
            if (err_r == ST_OK) begin
              if (depth_r == DW'(1)) begin
                out_data_nxt.value = $signed(tos_r);
              end else begin
                out_data_nxt.status = ST_LEFTOVER;
              end
            end
            depth_nxt = '0;
            err_nxt   = ST_OK;
          end
        end else if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (err_r == ST_OK) begin
            case (cmd.cls)
              CL_PUSH: begin
                if (depth_r == DW'(STACK_DEPTH)) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  ram_we    = depth_r != '0;
                  tos_nxt   = WORD_W'(cmd.digit);
                  depth_nxt = depth_r + DW'(1);
                end
              end
              CL_ADD, CL_SUB, CL_MUL, CL_DIV: begin
                if (depth_r < DW'(2)) begin
                  err_nxt = ST_UNDERFLOW;
                end else begin
                  ram_re    = 1'b1;
                  op_nxt    = cmd.cls;
                  state_nxt = S_OPRD;
                end
              end
              CL_ERR: begin
                err_nxt = cmd.err;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_OPRD: begin
        state_nxt = S_IDLE;
        case (op_r)
          CL_ADD: begin
            tos_nxt   = lhs + tos_r;
            depth_nxt = depth_m1;
          end
          CL_SUB: begin
            tos_nxt   = lhs - tos_r;
            depth_nxt = depth_m1;
          end
          CL_MUL: begin
            tos_nxt   = lhs * tos_r;
            depth_nxt = depth_m1;
          end
          CL_DIV: begin
            if (tos_r == '0) begin
              err_nxt = ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          tos_nxt   = div_quo;
          depth_nxt = depth_m1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tos_r      <= tos_nxt;
    op_r       <= op_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/rpn_stack_evaluator.sv
// reverse polish expression evaluator, one pre-split token per input word
// input channel: in_valid / in_ready / in_data (token_kind, digit_value)
// output channel: out_valid / out_ready / out_data (value, status), one word
//   per end-of-expression token, none for any other token
// a front stage classifies tokens into a two-entry command queue; the back
//   stage owns the stack (top in a register, the rest in a ram) and executes
// per token in the back: a digit push or error token is handled in the idle state; add,
//   subtract and multiply read the left operand from the ram, then compute;
//   divide then waits on the bit-serial 32-step divider
// end marker: queued, then registered into out_valid by the idle back
// tokens after a latched error are dropped until the end marker
// reset (synchronous, active low) empties the queue and the stack, clears the
//   error and arms the first-token check; no clearing pass is needed
// a stalled receiver holds the result word in the output register; the
//   back keeps executing non-end tokens, and the queue keeps taking tokens
//   until it fills
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rpn_pkg::out_t out_data
);
  import rpn_pkg::*;

  // command queue between front and back
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // classify tokens, track the first token of each expression
  rpn_front u_rpn_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // stack, arithmetic, error latch and result register
  rpn_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_rpn_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### src/rpn_checker.sv
module rpn_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input rpn_pkg::out_t out_data
);
  import rpn_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.value == '0)
    else $error("error result with nonzero value");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_FIRST)
    else $error("undefined status code");

  // reset empties the output register and the queue
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
